[sv/positional_integer_list_core_macros.svh]
// Assertion macros used by the positional integer list controller.
`ifndef POSITIONAL_INTEGER_LIST_CORE_MACROS_SVH
`define POSITIONAL_INTEGER_LIST_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PIL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PIL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pil_pkg.sv]
// Types and codes for the positional integer list.
package pil_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         position;
        logic signed [31:0] new_value;
    } pil_req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [4:0]         length_after;
    } pil_rsp_t;

    typedef struct packed {
        logic       append;
        logic       insert;
        logic       remove;
        logic [3:0] position;
    } pil_cmd_t;

endpackage

[sv/positional_integer_list_core.sv]
// Top level of the positional integer list: controller and a row of entry cells.
//
//  channel   | handshake     | payload
//  ----------+---------------+---------------------------------------------
//  request   | start / busy  | opcode, position, new_value
//  result    | done          | read_value, status, length_after
//
//  The cells shift in parallel at the transfer edge of each request.
//  The result is shown in the cycle after the transfer, on done, for one cycle.
//  busy stays low, so a new request may follow in every cycle.
//  Reset clears the length; entry contents are undefined until written.
//  The receiver cannot stall the result.
module positional_integer_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pil_pkg::pil_req_t request,
    output logic              done,
    output pil_pkg::pil_rsp_t result
);
    import pil_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ADDR_N = 16;

    logic               accept;
    pil_cmd_t           cmd;
    logic [CNT_W-1:0]   count;
    logic signed [31:0] cell_data [CAPACITY];
    logic signed [31:0] rd_arr [ADDR_N];
    logic signed [31:0] rd_value;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [31:0] left_in;
            logic signed [31:0] right_in;
            if (gi == 0)
            begin : g_first
                assign left_in = '0;
            end
            else
            begin : g_inner_l
                assign left_in = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_in = cell_data[gi];
            end
            else
            begin : g_inner_r
                assign right_in = cell_data[gi+1];
            end
            pil_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .count      (count),
                .new_value  (request.new_value),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[gi])
            );
        end
        for (gi = 0; gi < ADDR_N; gi++)
        begin : g_rd
            if (gi < CAPACITY)
            begin : g_live
                assign rd_arr[gi] = cell_data[gi];
            end
            else
            begin : g_none
                assign rd_arr[gi] = '0;
            end
        end
    endgenerate

    assign rd_value = rd_arr[request.position];

    pil_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req      (request),
        .rd_value (rd_value),
        .cmd      (cmd),
        .count    (count),
        .done     (done),
        .rsp      (result)
    );

endmodule

[sv/pil_cell.sv]
// One list cell: holds one entry and shifts toward either neighbor.
module pil_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                clk,
    input  pil_pkg::pil_cmd_t   cmd,
    input  logic [CNT_W-1:0]    count,
    input  logic signed [31:0]  new_value,
    input  logic signed [31:0]  left_data,
    input  logic signed [31:0]  right_data,
    output logic signed [31:0]  data
);
    import pil_pkg::*;

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               at_pos;
    logic               above_pos;
    logic               at_count;

    assign at_pos    = INDEX == int'(cmd.position);
    assign above_pos = INDEX > int'(cmd.position);
    assign at_count  = INDEX == int'(count);

    always_comb
    begin
        if (cmd.insert && at_pos)
        begin
            data_next = new_value;
        end
        else if (cmd.insert && above_pos)
        begin
            data_next = left_data;
        end
        else if (cmd.remove && (at_pos || above_pos))
        begin
            data_next = right_data;
        end
        else if (cmd.append && at_count)
        begin
            data_next = new_value;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[sv/pil_ctrl.sv]
// List controller: length count, request checks, cell commands and result register.
module pil_ctrl #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  pil_pkg::pil_req_t  req,
    input  logic signed [31:0] rd_value,
    output pil_pkg::pil_cmd_t  cmd,
    output logic [CNT_W-1:0]   count,
    output logic               done,
    output pil_pkg::pil_rsp_t  rsp
);
    import pil_pkg::*;

    localparam int CMP_W = CNT_W + 4;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    logic               done_next;
    pil_rsp_t           rsp_reg;
    pil_rsp_t           rsp_next;
    logic [CNT_W-1:0]   count_op;
    logic [1:0]         status;
    logic signed [31:0] value;
    logic               pos_ge;
    logic               full;
    logic               do_append;
    logic               do_insert;
    logic               do_remove;
    logic [CNT_W+4:0]   len_ext;

    assign pos_ge = CMP_W'(req.position) >= CMP_W'(count_reg);
    assign full   = count_reg == CNT_W'(CAPACITY);

    always_comb
    begin
        status    = ST_OK;
        value     = '0;
        count_op  = count_reg;
        do_append = 1'b0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        case (req.opcode)
            OP_APPEND:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_append = 1'b1;
                    count_op  = count_reg + 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (pos_ge)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                    count_op  = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos_ge)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    do_remove = 1'b1;
                    value     = rd_value;
                    count_op  = count_reg - 1'b1;
                end
            end
            OP_READ:
            begin
                if (pos_ge)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    value = rd_value;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign cmd.append   = accept && do_append;
    assign cmd.insert   = accept && do_insert;
    assign cmd.remove   = accept && do_remove;
    assign cmd.position = req.position;

    assign count_next = accept ? count_op : count_reg;
    assign done_next  = accept;
    assign len_ext    = (CNT_W + 5)'(count_op);

    always_comb
    begin
        rsp_next = rsp_reg;
        if (accept)
        begin
            rsp_next.read_value   = value;
            rsp_next.status       = status;
            rsp_next.length_after = len_ext[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign count = count_reg;
    assign done  = done_reg;
    assign rsp   = rsp_reg;

`include "positional_integer_list_core_macros.svh"

    `PIL_ASSERT_NEXT(a_done_follows, clk, rst_n, accept, done_reg, "no result after transfer")
    `PIL_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY), "count over capacity")
    `PIL_ASSERT_NOW(a_full_count, clk, rst_n, done_reg && rsp_reg.status == ST_FULL, count_reg == CNT_W'(CAPACITY), "full reported below capacity")
    `PIL_ASSERT_NOW(a_err_zero, clk, rst_n, done_reg && rsp_reg.status != ST_OK, rsp_reg.read_value == 32'sd0, "error result carries data")

endmodule

[dv/pil_checker.sv]
// Checker for the positional integer list: predicts each result and compares.
`timescale 1ns / 100ps

module pil_checker
    import pil_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  pil_req_t request,
    input  logic     done,
    input  pil_rsp_t result,
    output int       errors,
    output int       awaiting,
    output int       compared,
    output int       full_seen,
    output int       range_seen
);

    logic signed [31:0] list_words [16];
    int                 list_len;
    pil_rsp_t           awaited_results [$];

    function automatic pil_rsp_t apply_request(pil_req_t r);
        pil_rsp_t rsp;
        int       pos;
        pos = int'(r.position);
        rsp = '0;
        rsp.status = ST_OK;
        case (r.opcode)
            OP_APPEND:
            begin
                if (list_len >= 16)
                begin
                    rsp.status = ST_FULL;
                end
                else
                begin
                    list_words[list_len] = r.new_value;
                    list_len++;
                end
            end
            OP_INSERT:
            begin
                if (pos >= list_len)
                begin
                    rsp.status = ST_RANGE;
                end
                else if (list_len >= 16)
                begin
                    rsp.status = ST_FULL;
                end
                else
                begin
                    for (int i = list_len; i > pos; i--)
                    begin
                        list_words[i] = list_words[i - 1];
                    end
                    list_words[pos] = r.new_value;
                    list_len++;
                end
            end
            OP_REMOVE:
            begin
                if (pos >= list_len)
                begin
                    rsp.status = ST_RANGE;
                end
                else
                begin
                    rsp.read_value = list_words[pos];
                    for (int i = pos + 1; i < list_len; i++)
                    begin
                        list_words[i - 1] = list_words[i];
                    end
                    list_len--;
                end
            end
            default:
            begin
                if (pos >= list_len)
                begin
                    rsp.status = ST_RANGE;
                end
                else
                begin
                    rsp.read_value = list_words[pos];
                end
            end
        endcase
        rsp.length_after = 5'(list_len);
        return rsp;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    assign awaiting = awaited_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        pil_rsp_t want;
        if (!rst_n)
        begin
            list_len   = 0;
            errors     = 0;
            compared   = 0;
            full_seen  = 0;
            range_seen = 0;
            awaited_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("unexpected result transfer", 1, 0);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compared++;
                    if (want.status == ST_FULL)
                        full_seen++;
                    if (want.status == ST_RANGE)
                        range_seen++;
                    if (result.read_value !== want.read_value)
                        report_mismatch("read_value", result.read_value, want.read_value);
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                    if (result.length_after !== want.length_after)
                        report_mismatch("length_after", result.length_after,
                                        want.length_after);
                end
            end
            if (start && !busy)
            begin
                awaited_results.push_back(apply_request(request));
            end
        end
    end

endmodule

[dv/tb.sv]
// Testbench top for the positional integer list: stimulus, timeout and verdict.
`timescale 1ns / 100ps

module tb;
    import pil_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    pil_req_t request = '0;
    logic     done;
    pil_rsp_t result;

    int errors;
    int awaiting;
    int compared;
    int full_seen;
    int range_seen;

    int cycles = 0;
    int sent = 0;
    int shadow_len = 0;
    int idle_pct = 7;
    bit growing = 1'b1;

    positional_integer_list_core #(.CAPACITY(16)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    pil_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .errors     (errors),
        .awaiting   (awaiting),
        .compared   (compared),
        .full_seen  (full_seen),
        .range_seen (range_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // length tracking only, for steering positions and the fill/drain walk
    function automatic int length_after(logic [1:0] op, logic [3:0] pos, int len);
        if (op == OP_APPEND && len < 16)
            return len + 1;
        if (op == OP_INSERT && int'(pos) < len && len < 16)
            return len + 1;
        if (op == OP_REMOVE && int'(pos) < len)
            return len - 1;
        return len;
    endfunction

    task automatic send(logic [1:0] op, logic [3:0] pos, logic [31:0] val);
        pil_req_t r;
        bit       gap;
        r.opcode    = op;
        r.position  = pos;
        r.new_value = val;
        gap = 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            if (!gap)
                start <= 1'b0;
            gap = 1'b1;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        shadow_len = length_after(op, pos, shadow_len);
        sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_position();
        if (shadow_len == 0 || $urandom_range(99) < 15)
            return 4'($urandom_range(15));
        return 4'($urandom_range(shadow_len - 1));
    endfunction

    task automatic send_random();
        int          r;
        logic [1:0]  op;
        r = $urandom_range(99);
        if (growing)
            op = (r < 45) ? OP_APPEND : (r < 70) ? OP_INSERT : (r < 85) ? OP_READ : OP_REMOVE;
        else
            op = (r < 20) ? OP_APPEND : (r < 30) ? OP_INSERT : (r < 50) ? OP_READ : OP_REMOVE;
        send(op, pick_position(), pick_value());
        if (shadow_len == 16 && $urandom_range(3) == 0)
            growing = 1'b0;
        else if (shadow_len == 0 && $urandom_range(2) == 0)
            growing = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every positional request is out of range
        send(OP_READ, 4'd0, 32'h0);
        send(OP_INSERT, 4'd0, 32'h1234_5678);
        send(OP_REMOVE, 4'd15, 32'h0);
        // fill to capacity, extremes first
        send(OP_APPEND, 4'd0, 32'h8000_0000);
        send(OP_APPEND, 4'd15, 32'h7FFF_FFFF);
        send(OP_APPEND, 4'd0, 32'h0);
        send(OP_APPEND, 4'd9, 32'hFFFF_FFFF);
        while (shadow_len < 16)
            send(OP_APPEND, 4'($urandom_range(15)), $urandom);
        send(OP_APPEND, 4'd0, 32'hDEAD_BEEF);
        send(OP_INSERT, 4'd15, 32'h5A5A_5A5A);
        send(OP_READ, 4'd15, 32'h0);
        send(OP_REMOVE, 4'd0, 32'h0);
        // insert at the end position is rejected, one below is accepted
        send(OP_INSERT, 4'd15, 32'hA5A5_A5A5);
        send(OP_INSERT, 4'd14, 32'h8000_0001);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 7 : (phase == 1) ? 65 : 0;
            repeat (200)
                send_random();
        end
        start <= 1'b0;

        while (awaiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d requests over three idle profiles; %0d results compared.",
                 sent, compared);
        $display("Results with list full: %0d, out of range: %0d.", full_seen, range_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
